// ===== design/relation_language_tokenizer_core_macros.svh =====
// assertion macros shared by the tokenizer modules
// no dependencies; included by files that carry assertions
`ifndef RELATION_LANGUAGE_TOKENIZER_CORE_MACROS_SVH
`define RELATION_LANGUAGE_TOKENIZER_CORE_MACROS_SVH

// checked on every clock edge out of reset
`define RLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define RLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rlt_pkg.sv =====
// shared types, constants and keyword table for the tokenizer
// no dependencies; used by all tokenizer modules
`timescale 1ns / 1ps
package rlt_pkg;

  localparam int KW_CHARS = 10;
  localparam int POS_BITS = 16;
  localparam int NKW = 18;
  localparam int KW_MAXLEN = 10;
  localparam int WL_BITS = $clog2(KW_CHARS + 1);
  localparam int WI_BITS = $clog2(KW_CHARS);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW = $clog2(OQ_DEPTH);
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW = $clog2(CQ_DEPTH);
  localparam int MAX_RES = 3;

  localparam logic [2:0] K_TEXT    = 3'd0;
  localparam logic [2:0] K_SINGLE  = 3'd1;
  localparam logic [2:0] K_ARROW   = 3'd2;
  localparam logic [2:0] K_STRING  = 3'd3;
  localparam logic [2:0] K_IDENT   = 3'd4;
  localparam logic [2:0] K_FNAME   = 3'd5;
  localparam logic [2:0] K_KEYWORD = 3'd6;
  localparam logic [2:0] K_END     = 3'd7;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_AFTER_CR  = 4'd1;
  localparam logic [3:0] PH_AFTER_LF  = 4'd2;
  localparam logic [3:0] PH_COMMENT   = 4'd3;
  localparam logic [3:0] PH_DASH      = 4'd4;
  localparam logic [3:0] PH_STR_FIRST = 4'd5;
  localparam logic [3:0] PH_STR_BODY  = 4'd6;
  localparam logic [3:0] PH_STR_ESC   = 4'd7;
  localparam logic [3:0] PH_WORD      = 4'd8;
  localparam logic [3:0] PH_FNAME     = 4'd9;

  localparam logic [1:0] MODE_WORD  = 2'd0;
  localparam logic [1:0] MODE_FNAME = 2'd1;

  localparam logic [7:0] CH_DASH = 8'h2D;

  // keyword text, right-justified: char j of a keyword of length n at byte n-1-j
  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [NKW] = '{
    "DOMAIN", "RELATION", "OPERATION", "DOMAINS", "RELATIONS",
    "OPERATIONS", "NEGATIONS", "FUNCTIONS", "LIST", "DELETE", "AS",
    "TABLE", "LOAD", "NEGATION", "FORMULA", "PATH", "X", "Y"
  };
  localparam int KW_LEN [NKW] = '{
    6, 8, 9, 7, 9, 10, 9, 9, 4, 6, 2, 5, 4, 8, 7, 4, 1, 1
  };

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       blank;
    logic       cr;
    logic       lf;
    logic       hash;
    logic       dash;
    logic       quote;
    logic       bslash;
    logic       gt;
    logic       wchar;
    logic       fchar;
  } cls_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  kwi;
    logic [7:0]  ch;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } res_t;

  function automatic pos_t sat_add(pos_t v, logic [1:0] a);
    logic [POS_BITS:0] s;
    s = {1'b0, v} + (POS_BITS + 1)'(a);
    return s[POS_BITS] ? '1 : s[POS_BITS-1:0];
  endfunction

  function automatic logic [15:0] pos_out(pos_t v);
    logic [POS_BITS+15:0] w;
    w = {16'b0, v};
    return (w > (POS_BITS + 16)'(17'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

// ===== design/rlt_front.sv =====
// front end: accepts characters, classifies them, holds them in a short queue
// depends on rlt_pkg
`timescale 1ns / 1ps
module rlt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    in_char_code,
  input  logic          in_end_of_input,
  input  logic          take,
  output logic          cmd_valid,
  output rlt_pkg::cls_t cmd
);

  rlt_pkg::cls_t                q_r [rlt_pkg::CQ_DEPTH];
  logic [rlt_pkg::CQ_AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [rlt_pkg::CQ_AW:0]      cnt_r, cnt_nxt;
  rlt_pkg::cls_t                cls;
  logic                         acc;
  logic [7:0]                   c;
  logic                         alpha, digit;

  always_comb begin
    c = in_char_code;
    alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    digit = (c >= 8'h30 && c <= 8'h39);
    cls.ch     = c;
    cls.eoi    = in_end_of_input;
    cls.blank  = (c == 8'h20) || (c == 8'h09);
    cls.cr     = (c == 8'h0D);
    cls.lf     = (c == 8'h0A);
    cls.hash   = (c == 8'h23);
    cls.dash   = (c == 8'h2D);
    cls.quote  = (c == 8'h22);
    cls.bslash = (c == 8'h5C);
    cls.gt     = (c == 8'h3E);
    cls.wchar  = alpha || digit || (c == 8'h5F);
    cls.fchar  = alpha || digit || (c == 8'h5F) || (c == 8'h2E) || (c == 8'h2F)
                 || (c == 8'h5C);
  end

  assign full      = (cnt_r == (rlt_pkg::CQ_AW + 1)'(rlt_pkg::CQ_DEPTH));
  assign acc       = push && !full;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = acc ? wp_r + 1'b1 : wp_r;
    rp_nxt  = take ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (rlt_pkg::CQ_AW + 1)'(acc) - (rlt_pkg::CQ_AW + 1)'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

// ===== design/rlt_back.sv =====
// back end: tokenizer state machine, keyword match, position counters
// depends on rlt_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "relation_language_tokenizer_core_macros.svh"
module rlt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata,
  input  logic          cmd_valid,
  input  rlt_pkg::cls_t cmd,
  output logic          take,
  input  logic          oq_ready,
  output logic [1:0]    res_n,
  output rlt_pkg::res_t res [rlt_pkg::MAX_RES]
);

  logic [1:0]                 mode_r;
  logic [3:0]                 ph_r, ph;
  logic [7:0]                 kb_r [rlt_pkg::KW_CHARS];
  logic [rlt_pkg::WL_BITS-1:0] wl_r, wl;
  logic                       wtl_r, wtl;
  rlt_pkg::pos_t              ln_r, ln, col_r, col, tl_r, tl, tc_r, tc;
  logic                       kb_we;
  logic [rlt_pkg::WI_BITS-1:0] kb_idx;
  logic [7:0]                 kb_dat;
  logic                       kw_hit;
  logic [4:0]                 kw_idx;
  logic                       ok;
  logic                       do_idle;
  logic [1:0]                 n;
  logic [2:0]                 fin_kind;
  logic                       do_word;
  logic [7:0]                 c;

  assign take = cmd_valid && oq_ready;

  function automatic rlt_pkg::res_t mk(logic [2:0] k, logic [4:0] i, logic [7:0] ch,
                                       rlt_pkg::pos_t l, rlt_pkg::pos_t cc);
    rlt_pkg::res_t r;
    r.kind = k;
    r.kwi  = i;
    r.ch   = ch;
    r.line = rlt_pkg::pos_out(l);
    r.col  = rlt_pkg::pos_out(cc);
    r.last = 1'b0;
    return r;
  endfunction

  // keyword compare against the stored word
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int i = rlt_pkg::NKW - 1; i >= 0; i--) begin
      ok = (wl_r == rlt_pkg::WL_BITS'(rlt_pkg::KW_LEN[i])) && !wtl_r;
      for (int j = 0; j < rlt_pkg::KW_MAXLEN; j++) begin
        if (j < rlt_pkg::KW_LEN[i]) begin
          if (kb_r[j] != rlt_pkg::KW_TEXT[i][8*(rlt_pkg::KW_LEN[i]-1-j) +: 8]) begin
            ok = 1'b0;
          end
        end
      end
      if (ok) begin
        kw_hit = 1'b1;
        kw_idx = 5'(i);
      end
    end
  end

  always_comb begin
    ph = ph_r; ln = ln_r; col = col_r; tl = tl_r; tc = tc_r;
    wl = wl_r; wtl = wtl_r;
    kb_we = 1'b0; kb_idx = '0; kb_dat = '0;
    n = '0;
    do_idle = 1'b0;
    do_word = 1'b0;
    fin_kind = rlt_pkg::K_IDENT;
    c = cmd.ch;
    for (int k = 0; k < rlt_pkg::MAX_RES; k++) begin
      res[k] = '0;
    end
    if (cmd.eoi) begin
      unique case (ph_r)
        rlt_pkg::PH_WORD, rlt_pkg::PH_FNAME: begin
          fin_kind = (ph_r == rlt_pkg::PH_WORD) ? rlt_pkg::K_IDENT : rlt_pkg::K_FNAME;
          res[n] = mk(kw_hit ? rlt_pkg::K_KEYWORD : fin_kind, kw_hit ? kw_idx : 5'd0,
                      8'd0, tl, tc);
          n = n + 2'd1;
        end
        rlt_pkg::PH_DASH: begin
          res[n] = mk(rlt_pkg::K_SINGLE, 5'd0, rlt_pkg::CH_DASH, tl, tc);
          n = n + 2'd1;
          col = rlt_pkg::sat_add(col, 2'd1);
        end
        rlt_pkg::PH_STR_FIRST, rlt_pkg::PH_STR_BODY, rlt_pkg::PH_STR_ESC: begin
          res[n] = mk(rlt_pkg::K_STRING, 5'd0, 8'd0, tl, tc);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      res[n] = mk(rlt_pkg::K_END, 5'd0, 8'd0, ln, col);
      n = n + 2'd1;
      ph = rlt_pkg::PH_IDLE;
    end else begin
      unique case (ph_r)
        rlt_pkg::PH_AFTER_CR: begin
          ph = rlt_pkg::PH_IDLE;
          do_idle = !cmd.lf;
        end
        rlt_pkg::PH_AFTER_LF: begin
          ph = rlt_pkg::PH_IDLE;
          do_idle = !cmd.cr;
        end
        rlt_pkg::PH_COMMENT: begin
          do_idle = cmd.cr || cmd.lf;
        end
        rlt_pkg::PH_DASH: begin
          ph = rlt_pkg::PH_IDLE;
          if (cmd.gt) begin
            res[n] = mk(rlt_pkg::K_ARROW, 5'd0, 8'd0, tl, tc);
            n = n + 2'd1;
            col = rlt_pkg::sat_add(col, 2'd2);
          end else begin
            res[n] = mk(rlt_pkg::K_SINGLE, 5'd0, rlt_pkg::CH_DASH, tl, tc);
            n = n + 2'd1;
            col = rlt_pkg::sat_add(col, 2'd1);
            do_idle = 1'b1;
          end
        end
        rlt_pkg::PH_STR_FIRST, rlt_pkg::PH_STR_BODY: begin
          if (cmd.quote) begin
            col = rlt_pkg::sat_add(col, 2'd1);
            res[n] = mk(rlt_pkg::K_STRING, 5'd0, 8'd0, tl, tc);
            n = n + 2'd1;
            ph = rlt_pkg::PH_IDLE;
          end else if (cmd.bslash && ph_r == rlt_pkg::PH_STR_BODY) begin
            ph = rlt_pkg::PH_STR_ESC;
          end else begin
            res[n] = mk(rlt_pkg::K_TEXT, 5'd0, c, tl, tc);
            n = n + 2'd1;
            col = rlt_pkg::sat_add(col, 2'd1);
            ph = rlt_pkg::PH_STR_BODY;
          end
        end
        rlt_pkg::PH_STR_ESC: begin
          col = rlt_pkg::sat_add(col, 2'd2);
          res[n] = mk(rlt_pkg::K_TEXT, 5'd0, c, tl, tc);
          n = n + 2'd1;
          ph = rlt_pkg::PH_STR_BODY;
        end
        rlt_pkg::PH_WORD, rlt_pkg::PH_FNAME: begin
          if ((ph_r == rlt_pkg::PH_WORD) ? cmd.wchar : cmd.fchar) begin
            do_word = 1'b1;
          end else begin
            fin_kind = (ph_r == rlt_pkg::PH_WORD) ? rlt_pkg::K_IDENT : rlt_pkg::K_FNAME;
            res[n] = mk(kw_hit ? rlt_pkg::K_KEYWORD : fin_kind, kw_hit ? kw_idx : 5'd0,
                        8'd0, tl, tc);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
      if (do_idle) begin
        ph = rlt_pkg::PH_IDLE;
        priority if (cmd.blank) begin
          col = rlt_pkg::sat_add(col, 2'd1);
        end else if (cmd.cr || cmd.lf) begin
          ln = rlt_pkg::sat_add(ln, 2'd1);
          col = rlt_pkg::pos_t'(1);
          ph = cmd.cr ? rlt_pkg::PH_AFTER_CR : rlt_pkg::PH_AFTER_LF;
        end else if (cmd.hash) begin
          ph = rlt_pkg::PH_COMMENT;
        end else begin
          tl = ln;
          tc = col;
          priority if (cmd.dash) begin
            ph = rlt_pkg::PH_DASH;
          end else if (cmd.quote) begin
            ph = rlt_pkg::PH_STR_FIRST;
          end else if ((mode_r == rlt_pkg::MODE_WORD && cmd.wchar) ||
                       (mode_r == rlt_pkg::MODE_FNAME && cmd.fchar)) begin
            wl = '0;
            wtl = 1'b0;
            ph = (mode_r == rlt_pkg::MODE_WORD) ? rlt_pkg::PH_WORD : rlt_pkg::PH_FNAME;
            do_word = 1'b1;
          end else begin
            res[n] = mk(rlt_pkg::K_SINGLE, 5'd0, c, tl, tc);
            n = n + 2'd1;
            col = rlt_pkg::sat_add(col, 2'd1);
          end
        end
      end
      if (do_word) begin
        if (wl < rlt_pkg::WL_BITS'(rlt_pkg::KW_CHARS)) begin
          kb_we = 1'b1;
          kb_idx = wl[rlt_pkg::WI_BITS-1:0];
          kb_dat = c;
          wl = wl + 1'b1;
        end else begin
          wtl = 1'b1;
        end
        res[n] = mk(rlt_pkg::K_TEXT, 5'd0, c, tl, tc);
        n = n + 2'd1;
        col = rlt_pkg::sat_add(col, 2'd1);
      end
    end
    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
    res_n = take ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rlt_pkg::MODE_WORD;
      ph_r   <= rlt_pkg::PH_IDLE;
      wl_r   <= '0;
      wtl_r  <= 1'b0;
      ln_r   <= rlt_pkg::pos_t'(1);
      col_r  <= rlt_pkg::pos_t'(1);
      tl_r   <= rlt_pkg::pos_t'(1);
      tc_r   <= rlt_pkg::pos_t'(1);
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (take) begin
        ph_r  <= ph;
        wl_r  <= wl;
        wtl_r <= wtl;
        ln_r  <= ln;
        col_r <= col;
        tl_r  <= tl;
        tc_r  <= tc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && kb_we) begin
      kb_r[kb_idx] <= kb_dat;
    end
  end

  `RLT_ASSERT(a_eoi_gives_end, take && cmd.eoi |-> res_n != 2'd0 && res[res_n - 2'd1].kind == rlt_pkg::K_END, "end of input without end item")
  `RLT_ASSERT(a_eoi_to_idle, take && cmd.eoi |=> ph_r == rlt_pkg::PH_IDLE, "phase not idle after end of input")
  `RLT_ASSERT(a_wl_bound, wl_r <= rlt_pkg::WL_BITS'(rlt_pkg::KW_CHARS), "word length beyond buffer")

endmodule

// ===== design/rlt_outq.sv =====
// result queue: takes up to three items a cycle, hands out one
// depends on rlt_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "relation_language_tokenizer_core_macros.svh"
module rlt_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    wr_n,
  input  rlt_pkg::res_t wr_res [rlt_pkg::MAX_RES],
  output logic          ready,
  input  logic          pop,
  output logic          empty,
  output rlt_pkg::res_t head
);

  rlt_pkg::res_t              ent_r [rlt_pkg::OQ_DEPTH];
  logic [rlt_pkg::OQ_AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [rlt_pkg::OQ_AW:0]    cnt_r, cnt_nxt;
  logic                       deq;

  assign empty = (cnt_r == '0);
  assign deq   = pop && !empty;
  assign head  = ent_r[rp_r];
  assign ready = cnt_r <= (rlt_pkg::OQ_AW + 1)'(rlt_pkg::OQ_DEPTH - rlt_pkg::MAX_RES);

  always_comb begin
    wp_nxt  = wp_r + rlt_pkg::OQ_AW'(wr_n);
    rp_nxt  = deq ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (rlt_pkg::OQ_AW + 1)'(wr_n) - (rlt_pkg::OQ_AW + 1)'(deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < rlt_pkg::MAX_RES; k++) begin
      if (2'(k) < wr_n) begin
        ent_r[wp_r + rlt_pkg::OQ_AW'(k)] <= wr_res[k];
      end
    end
  end

  `RLT_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= (rlt_pkg::OQ_AW + 1)'(rlt_pkg::OQ_DEPTH), "result queue count overflow")
  `RLT_ASSERT(a_no_overrun, wr_n != 2'd0 |-> ready, "results written without room")
  `RLT_ASSERT(a_last_at_tail, wr_n != 2'd0 |-> wr_res[wr_n - 2'd1].last, "last flag missing on final item")

endmodule

// ===== design/relation_language_tokenizer_core.sv =====
// top level of the relation language tokenizer
// depends on rlt_pkg, rlt_front, rlt_back and rlt_outq
`timescale 1ns / 1ps
// Takes one character per cycle while full is low, through a push/full
// queue port, and returns token items through an empty/pop queue port,
// oldest first. A character is classified and parked in a two-entry input
// queue, then the tokenizer state machine consumes one per cycle and writes
// zero to three items into an eight-entry result queue; the result queue
// registers the items of a character before the first of them shows on the
// outputs. Sustained input rate is one character per cycle while results
// are popped as fast as they appear; characters that yield several items are
// held to the one-per-cycle drain of the result queue, and the tokenizer
// takes a character only when the result queue has room for three items.
// The mode register may be written only while the block is idle.
module relation_language_tokenizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [4:0]  out_keyword_index,
  output logic [7:0]  out_char_value,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic        out_last
);

  rlt_pkg::cls_t cmd;
  logic          cmd_valid;
  logic          take;
  logic          oq_ready;
  logic [1:0]    res_n;
  rlt_pkg::res_t res [rlt_pkg::MAX_RES];
  rlt_pkg::res_t head;

  rlt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_char_code    (in_char_code),
    .in_end_of_input (in_end_of_input),
    .take            (take),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd)
  );

  rlt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take),
    .oq_ready  (oq_ready),
    .res_n     (res_n),
    .res       (res)
  );

  rlt_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_n   (res_n),
    .wr_res (res),
    .ready  (oq_ready),
    .pop    (pop),
    .empty  (empty),
    .head   (head)
  );

  assign out_kind          = head.kind;
  assign out_keyword_index = head.kwi;
  assign out_char_value    = head.ch;
  assign out_start_line    = head.line;
  assign out_start_column  = head.col;
  assign out_last          = head.last;

endmodule

// ===== tb/tb_relation_language_tokenizer_core.sv =====
// testbench for relation_language_tokenizer_core: directed and random character streams
// depends on rlt_pkg and the tokenizer rtl; results checked against a built-in predictor
`timescale 1ns / 1ps
module tb_relation_language_tokenizer_core;
  import rlt_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RAND_ITEMS = 360;
  localparam int POS_MAX = 65535;
  localparam logic [7:0] C_SP = 8'h20, C_TAB = 8'h09, C_CR = 8'h0D, C_LF = 8'h0A;
  localparam logic [7:0] C_HASH = 8'h23, C_QUOTE = 8'h22, C_BSL = 8'h5C, C_GT = 8'h3E;
  localparam logic [1:0] MODE_CROSS = 2'd2, MODE_STRAY = 2'd3;

  logic clk, rst_n, cfg_we, push, full, empty, pop;
  logic [1:0] cfg_wdata;
  logic [7:0] in_char_code;
  logic in_end_of_input;
  logic [2:0] out_kind;
  logic [4:0] out_keyword_index;
  logic [7:0] out_char_value;
  logic [15:0] out_start_line, out_start_column;
  logic out_last;

  relation_language_tokenizer_core u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .in_char_code(in_char_code),
    .in_end_of_input(in_end_of_input), .empty(empty), .pop(pop),
    .out_kind(out_kind), .out_keyword_index(out_keyword_index),
    .out_char_value(out_char_value), .out_start_line(out_start_line),
    .out_start_column(out_start_column), .out_last(out_last)
  );

  string keywords [NKW] = '{
    "DOMAIN", "RELATION", "OPERATION", "DOMAINS", "RELATIONS",
    "OPERATIONS", "NEGATIONS", "FUNCTIONS", "LIST", "DELETE", "AS",
    "TABLE", "LOAD", "NEGATION", "FORMULA", "PATH", "X", "Y"
  };
  string word_pool = "ABDEILMNOPRSTUXYabz_09";

  // predictor state
  logic [1:0] lex_mode;
  logic [3:0] lex_phase;
  logic [7:0] word_buf [KW_CHARS];
  int word_len;
  bit word_long;
  int line_no, col_no, tok_line, tok_col;

  res_t token_queue[$];
  res_t step_out[$];
  int errors;
  int items_sent;
  int cycles;
  bit idle_on;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_relation_language_tokenizer_core NOT OK");
      $finish;
    end
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int sat(int v, int a);
    return (v + a > POS_MAX) ? POS_MAX : v + a;
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return c == "_" || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9");
  endfunction

  function automatic bit is_fname(logic [7:0] c);
    return is_word(c) || c == "." || c == "/" || c == C_BSL;
  endfunction

  function automatic void put(logic [2:0] k, int kw, logic [7:0] ch, int ln, int cl);
    res_t r;
    r.kind = k;
    r.kwi = kw[4:0];
    r.ch = ch;
    r.line = ln[15:0];
    r.col = cl[15:0];
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void text_out(logic [7:0] c);
    put(K_TEXT, 0, c, tok_line, tok_col);
    col_no = sat(col_no, 1);
  endfunction

  function automatic void single_out(logic [7:0] c);
    put(K_SINGLE, 0, c, tok_line, tok_col);
    col_no = sat(col_no, 1);
  endfunction

  function automatic void word_add(logic [7:0] c);
    if (word_len < KW_CHARS) begin
      word_buf[word_len] = c;
      word_len++;
    end else begin
      word_long = 1;
    end
    text_out(c);
  endfunction

  function automatic void word_end(logic [2:0] plain);
    bit hit;
    if (!word_long) begin
      for (int i = 0; i < NKW; i++) begin
        if (keywords[i].len() == word_len) begin
          hit = 1;
          for (int j = 0; j < word_len; j++)
            if (keywords[i][j] != word_buf[j]) hit = 0;
          if (hit) begin
            put(K_KEYWORD, i, 0, tok_line, tok_col);
            return;
          end
        end
      end
    end
    put(plain, 0, 0, tok_line, tok_col);
  endfunction

  function automatic void start_char(logic [7:0] c);
    lex_phase = PH_IDLE;
    if (c == C_SP || c == C_TAB) begin
      col_no = sat(col_no, 1);
    end else if (c == C_CR || c == C_LF) begin
      line_no = sat(line_no, 1);
      col_no = 1;
      lex_phase = (c == C_CR) ? PH_AFTER_CR : PH_AFTER_LF;
    end else if (c == C_HASH) begin
      lex_phase = PH_COMMENT;
    end else begin
      tok_line = line_no;
      tok_col = col_no;
      if (c == CH_DASH) begin
        lex_phase = PH_DASH;
      end else if (c == C_QUOTE) begin
        lex_phase = PH_STR_FIRST;
      end else if (lex_mode == MODE_WORD && is_word(c)) begin
        word_len = 0;
        word_long = 0;
        lex_phase = PH_WORD;
        word_add(c);
      end else if (lex_mode == MODE_FNAME && is_fname(c)) begin
        word_len = 0;
        word_long = 0;
        lex_phase = PH_FNAME;
        word_add(c);
      end else begin
        single_out(c);
      end
    end
  endfunction

  function automatic void tokenize(logic [7:0] c, logic eoi);
    step_out.delete();
    if (eoi) begin
      case (lex_phase)
        PH_WORD: word_end(K_IDENT);
        PH_FNAME: word_end(K_FNAME);
        PH_DASH: single_out(CH_DASH);
        PH_STR_FIRST, PH_STR_BODY, PH_STR_ESC: put(K_STRING, 0, 0, tok_line, tok_col);
        default: ;
      endcase
      put(K_END, 0, 0, line_no, col_no);
      lex_phase = PH_IDLE;
    end else begin
      case (lex_phase)
        PH_AFTER_CR: begin
          lex_phase = PH_IDLE;
          if (c != C_LF) start_char(c);
        end
        PH_AFTER_LF: begin
          lex_phase = PH_IDLE;
          if (c != C_CR) start_char(c);
        end
        PH_COMMENT: if (c == C_CR || c == C_LF) start_char(c);
        PH_DASH: begin
          lex_phase = PH_IDLE;
          if (c == C_GT) begin
            put(K_ARROW, 0, 0, tok_line, tok_col);
            col_no = sat(col_no, 2);
          end else begin
            single_out(CH_DASH);
            start_char(c);
          end
        end
        PH_STR_FIRST, PH_STR_BODY: begin
          if (c == C_QUOTE) begin
            col_no = sat(col_no, 1);
            put(K_STRING, 0, 0, tok_line, tok_col);
            lex_phase = PH_IDLE;
          end else if (c == C_BSL && lex_phase == PH_STR_BODY) begin
            lex_phase = PH_STR_ESC;
          end else begin
            text_out(c);
            lex_phase = PH_STR_BODY;
          end
        end
        PH_STR_ESC: begin
          col_no = sat(col_no, 1);
          text_out(c);
          lex_phase = PH_STR_BODY;
        end
        PH_WORD: begin
          if (is_word(c)) word_add(c);
          else begin
            word_end(K_IDENT);
            start_char(c);
          end
        end
        PH_FNAME: begin
          if (is_fname(c)) word_add(c);
          else begin
            word_end(K_FNAME);
            start_char(c);
          end
        end
        default: start_char(c);
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) token_queue.push_back(step_out[i]);
  endfunction

  // input side
  task automatic send_item(logic [7:0] c, logic eoi);
    bit taken;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    push <= 1'b1;
    in_char_code <= c;
    in_end_of_input <= eoi;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end
    tokenize(c, eoi);
    items_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (token_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    lex_mode = m;
  endtask

  // result side
  int stall_left;
  bit take;
  res_t seen;

  always @(negedge clk) begin
    take = pop && !empty;
    seen.kind = out_kind;
    seen.kwi = out_keyword_index;
    seen.ch = out_char_value;
    seen.line = out_start_line;
    seen.col = out_start_column;
    seen.last = out_last;
  end

  always @(posedge clk) begin
    if (rst_n && take) begin
      if (token_queue.size() == 0) begin
        report("unexpected item kind", seen.kind, -1);
      end else begin
        res_t w;
        w = token_queue.pop_front();
        if (seen.kind !== w.kind) report("kind", seen.kind, w.kind);
        if (seen.kwi !== w.kwi) report("keyword_index", seen.kwi, w.kwi);
        if (seen.ch !== w.ch) report("char_value", seen.ch, w.ch);
        if (seen.line !== w.line) report("start_line", seen.line, w.line);
        if (seen.col !== w.col) report("start_column", seen.col, w.col);
        if (seen.last !== w.last) report("last", seen.last, w.last);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // tests
  task automatic test_word_mode();
    set_mode(MODE_WORD);
    send_text("RELATION->\"a\\\"b\"#c\r\nX-y");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_filename_mode();
    set_mode(MODE_FNAME);
    send_text("a/b.c\\ \"\\x");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_cross_modes();
    set_mode(MODE_CROSS);
    send_text("ab\n\r-");
    send_item(8'h00, 1'b1);
    set_mode(MODE_STRAY);
    send_text("Z9\t-");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_mode_inside_word();
    set_mode(MODE_WORD);
    send_text("LO");
    set_mode(MODE_CROSS);
    send_text("AD ");
  endtask

  task automatic random_token();
    int n;
    case ($urandom_range(0, 10))
      0: send_text(keywords[$urandom_range(0, NKW - 1)]);
      1: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
        repeat (n) send_item(word_pool[$urandom_range(0, word_pool.len() - 1)], 1'b0);
      end
      2: begin
        send_item(C_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0) send_item(C_BSL, 1'b0);
          send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        if ($urandom_range(0, 4) != 0) send_item(C_QUOTE, 1'b0);
      end
      3: begin
        send_item(C_HASH, 1'b0);
        repeat ($urandom_range(0, 5)) send_item(8'($urandom_range(0, 255)), 1'b0);
        send_item($urandom_range(0, 1) ? C_CR : C_LF, 1'b0);
      end
      4: begin
        n = $urandom_range(0, 3);
        send_item((n < 2) ? C_CR : C_LF, 1'b0);
        send_item((n == 0 || n == 3) ? C_LF : C_CR, 1'b0);
      end
      5: begin
        send_item(CH_DASH, 1'b0);
        if ($urandom_range(0, 1)) send_item(C_GT, 1'b0);
      end
      6: send_item($urandom_range(0, 1) ? C_SP : C_TAB, 1'b0);
      7: send_item(8'($urandom_range(0, 255)), 1'b0);
      8: send_text("d/x.y\\z");
      9: send_item(8'($urandom_range(0, 255)), 1'b1);
      default: send_item(C_SP, 1'b0);
    endcase
    if ($urandom_range(0, 1)) send_item(C_SP, 1'b0);
  endtask

  task automatic test_random(int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(0, 60) == 0) set_mode(2'($urandom_range(0, 3)));
      random_token();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    push = 1'b0;
    pop = 1'b0;
    in_char_code = '0;
    in_end_of_input = 1'b0;
    lex_mode = MODE_WORD;
    lex_phase = PH_IDLE;
    word_len = 0;
    word_long = 0;
    line_no = 1;
    col_no = 1;
    tok_line = 1;
    tok_col = 1;
    errors = 0;
    items_sent = 0;
    cycles = 0;
    stall_left = 0;
    idle_on = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_word_mode();
    test_filename_mode();
    test_cross_modes();
    test_mode_inside_word();
    test_random(RAND_ITEMS - 120);
    idle_on = 0;
    test_random(60);
    drain();
    if (errors == 0)
      $display("tb_relation_language_tokenizer_core OK");
    else
      $display("tb_relation_language_tokenizer_core NOT OK");
    $finish;
  end
endmodule
